// ===== design/ffem_pkg.sv =====
// Shared types and constants for the feedforward echo mixer.
// No dependencies; compile first.
package ffem_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 17;
    localparam int DELAY_W    = 15;
    localparam int FILL_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAIL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
    localparam logic [FILL_W-1:0] FILL_MAX = 16'hFFFF;

    // Source of the delayed term
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_DIRECT,
        SEL_STORE
    } ffem_sel_t;

    // Item leaving the ring stage, aligned with the store read data
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] x;
        ffem_sel_t                  sel;
    } ffem_s1_t;

endpackage

// ===== design/ffem_in_if.sv =====
// Input channel of the echo mixer: valid/ready handshake with mode and sample.
// Depends on ffem_pkg.
interface ffem_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [ffem_pkg::MODE_W-1:0]          mode;
    logic signed [ffem_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output mode, output sample_in, input ready);
    modport sink   (input valid, input mode, input sample_in, output ready);
endinterface

// ===== design/ffem_out_if.sv =====
// Output channel of the echo mixer: valid/ready handshake with the mixed sample.
// Depends on ffem_pkg.
interface ffem_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ffem_pkg::SAMPLE_W-1:0] echoed_sample;

    modport source (output valid, output echoed_sample, input ready);
    modport sink   (input valid, input echoed_sample, output ready);
endinterface

// ===== design/feedforward_echo_mixer.sv =====
// Top level of the feedforward echo mixer: config registers, ring front end, mixer.
// Depends on ffem_pkg, ffem_in_if, ffem_out_if, ffem_ring, ffem_mix.
//
//  channel   dir  payload                      notes
//  in_ch     in   mode[1:0], sample_in[15:0]   sample, tail step, clear
//  out_ch    out  echoed_sample[15:0]          one item per sample or tail step
//  cfg       in   cfg_we, cfg_index, cfg_data  write only, idle block
//
// One item per cycle unless out_ch stalls; a result passes ring, product and output regs.
// The store RAM can take one write and one read per cycle, which sets that rate.
// Reset clears position, fill count and pipeline valids; the store is not swept.
// When out_ch stalls, every stage holds and in_ch.ready drops in the same cycle.
module feedforward_echo_mixer #(
    parameter int MAX_DELAY = 32768
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffem_pkg::CFG_DATA_W-1:0] cfg_data,
    ffem_in_if.sink                         in_ch,
    ffem_out_if.source                      out_ch
);
    import ffem_pkg::*;

    localparam int DLIM = (MAX_DELAY - 1 < 32767) ? MAX_DELAY - 1 : 32767;
    localparam logic [DELAY_W-1:0] D_LIMIT = DELAY_W'(DLIM);

    logic [GAIN_W-1:0]   gain_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0]   gain_eff;
    logic [DELAY_W-1:0]  delay_eff;
    logic                advance;
    logic                accept;
    ffem_s1_t            s1;
    logic [SAMPLE_W-1:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ECHO_GAIN:     gain_reg  <= cfg_data;
                REG_DELAY_SAMPLES: delay_reg <= cfg_data[DELAY_W-1:0];
                default:           ;
            endcase
        end
    end

    // Saturate gain at one and delay at the ring length minus one, capped at 32767
    assign gain_eff  = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign delay_eff = (delay_reg > D_LIMIT) ? D_LIMIT : delay_reg;

    assign in_ch.ready = advance;
    assign accept      = in_ch.valid && advance;

    ffem_ring #(
        .MAX_DELAY (MAX_DELAY)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .accept    (accept),
        .mode      (in_ch.mode),
        .sample_in (in_ch.sample_in),
        .delay     (delay_eff),
        .s1        (s1),
        .rdata     (rdata)
    );

    ffem_mix u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1      (s1),
        .rdata   (rdata),
        .gain    (gain_eff),
        .advance (advance),
        .out_ch  (out_ch)
    );

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s1))
        else $error("ring stage changed during a stall");

    a_result_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.mode == MODE_SAMPLE || in_ch.mode == MODE_TAIL) |=> s1.valid)
        else $error("sample or tail item lost in ring stage");

    a_no_result_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.mode != MODE_SAMPLE && in_ch.mode != MODE_TAIL |=> !s1.valid)
        else $error("clear or unused item produced a result");

    a_idle_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_ch.valid |=> !s1.valid)
        else $error("ring stage valid without an accepted item");

endmodule

// ===== design/ffem_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ffem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/ffem_ring.sv =====
// Ring front end: write position, fill count, delay store and read addressing.
// Depends on ffem_pkg and ffem_ram.
module ffem_ring #(
    parameter int MAX_DELAY = 32768
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 accept,
    input  logic [ffem_pkg::MODE_W-1:0]          mode,
    input  logic signed [ffem_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [ffem_pkg::DELAY_W-1:0]         delay,
    output ffem_pkg::ffem_s1_t                   s1,
    output logic [ffem_pkg::SAMPLE_W-1:0]        rdata
);
    import ffem_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int WW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam logic [AW-1:0] WP_LAST  = AW'(MAX_DELAY - 1);
    localparam logic [WW-1:0] RING_LEN = WW'(MAX_DELAY);

    logic [AW-1:0]              wp_reg, wp_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    ffem_s1_t                   s1_reg, s1_next;
    logic                       takes;
    logic signed [SAMPLE_W-1:0] x;
    logic [WW-1:0]              wp_w, d_w, rd_w;
    logic [AW-1:0]              raddr;

    assign takes = accept && (mode == MODE_SAMPLE || mode == MODE_TAIL);
    assign x     = (mode == MODE_SAMPLE) ? sample_in : '0;

    // Read address: write position minus delay, wrapped around the ring
    always_comb
    begin
        wp_w = WW'(wp_reg);
        d_w  = WW'(delay);
        if (wp_w >= d_w)
        begin
            rd_w = wp_w - d_w;
        end
        else
        begin
            rd_w = wp_w + RING_LEN - d_w;
        end
        raddr = rd_w[AW-1:0];
    end

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        s1_next   = s1_reg;
        if (advance)
        begin
            s1_next.valid = takes;
            s1_next.x     = x;
            if (delay == '0)
            begin
                s1_next.sel = SEL_DIRECT;
            end
            else if (fill_reg >= FILL_W'(delay))
            begin
                s1_next.sel = SEL_STORE;
            end
            else
            begin
                s1_next.sel = SEL_ZERO;
            end
        end
        if (accept && mode == MODE_CLEAR)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        else if (takes)
        begin
            wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
            if (fill_reg != FILL_MAX)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
            s1_reg   <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            s1_reg   <= s1_next;
        end
    end

    // Write and read land on different entries whenever the read is used
    ffem_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_store (
        .clk   (clk),
        .we    (takes),
        .waddr (wp_reg),
        .wdata (x),
        .re    (advance),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s1 = s1_reg;

endmodule

// ===== design/ffem_mix.sv =====
// Mixer datapath: gain products, sum with truncation toward zero, output register.
// Depends on ffem_pkg.
module ffem_mix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffem_pkg::ffem_s1_t            s1,
    input  logic [ffem_pkg::SAMPLE_W-1:0] rdata,
    input  logic [ffem_pkg::GAIN_W-1:0]   gain,
    output logic                          advance,
    ffem_out_if.source                    out_ch
);
    import ffem_pkg::*;

    localparam int PW = SAMPLE_W + GAIN_W + 1;
    localparam int AW = PW + 1;

    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [PW-1:0]       p_dir_reg, p_dir_next, p_del_reg, p_del_next;
    logic                       v2_reg;
    logic signed [AW-1:0]       acc, acc_adj;
    logic                       ov_reg;
    logic signed [SAMPLE_W-1:0] y_reg;

    assign advance = !ov_reg || out_ch.ready;

    always_comb
    begin
        case (s1.sel)
            SEL_DIRECT: delayed = s1.x;
            SEL_STORE:  delayed = $signed(rdata);
            default:    delayed = '0;
        endcase
        p_dir_next = $signed({1'b0, GAIN_W'(GAIN_ONE - gain)}) * s1.x;
        p_del_next = $signed({1'b0, gain}) * delayed;
    end

    // Divide by 2^16 toward zero: bias negative sums before the shift
    always_comb
    begin
        acc = AW'(p_dir_reg) + AW'(p_del_reg);
        if (acc[AW-1])
        begin
            acc_adj = acc + AW'(16'hFFFF);
        end
        else
        begin
            acc_adj = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= s1.valid;
            ov_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_dir_reg <= p_dir_next;
            p_del_reg <= p_del_next;
            y_reg     <= acc_adj[SAMPLE_W+15:16];
        end
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.echoed_sample = y_reg;

endmodule

// ===== bench/tb_feedforward_echo_mixer.sv =====
// Self-checking bench for feedforward_echo_mixer: random and directed sample clips
// against an in-bench echo predictor. Depends on ffem_pkg, ffem_in_if, ffem_out_if
// and the block's RTL.
module tb_feedforward_echo_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import ffem_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RING_DEPTH    = 32768;
    localparam int LONG_DELAY    = RING_DEPTH - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int REPORT_MAX    = 10;

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] sample;
        int                         gap;
        bit                         wait_drain;
    } echo_req_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ECHO_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ffem_in_if  in_if ();
    ffem_out_if out_if ();

    feedforward_echo_mixer #(
        .MAX_DELAY(RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Echo predictor state and register copies
    logic signed [SAMPLE_W-1:0] echo_ring [RING_DEPTH];
    int unsigned                ring_wr   = 0;
    int unsigned                clip_fill = 0;
    logic [GAIN_W-1:0]          gain_set  = '0;
    logic [DELAY_W-1:0]         delay_set = '0;

    logic signed [SAMPLE_W-1:0] echo_due [$];
    echo_req_t                  sample_feed [$];

    int tx_gap_max   = 7;
    int rx_stall_max = 7;
    int fed_count    = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    bit nothing_owed = 1'b1;

    function automatic void mix_echo(input logic [MODE_W-1:0] mode,
                                     input logic signed [SAMPLE_W-1:0] sample);
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] tap;
        int unsigned                g;
        int unsigned                d;
        longint                     acc;
        longint                     y;
        if (mode == MODE_CLEAR)
        begin
            clip_fill = 0;
            ring_wr   = 0;
            return;
        end
        if (mode == MODE_IGNORED)
            return;
        x   = (mode == MODE_SAMPLE) ? sample : '0;
        g   = (gain_set > GAIN_ONE) ? int'(GAIN_ONE) : int'(gain_set);
        d   = (delay_set > RING_DEPTH - 1) ? RING_DEPTH - 1 : int'(delay_set);
        tap = '0;
        if (d == 0)
            tap = x;
        else if (clip_fill >= d)
            tap = echo_ring[(ring_wr + RING_DEPTH - d) % RING_DEPTH];
        echo_ring[ring_wr] = x;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (clip_fill < FILL_MAX)
            clip_fill++;
        acc = longint'(int'(GAIN_ONE) - int'(g)) * longint'(x) + longint'(g) * longint'(tap);
        // signed division truncates toward zero
        y = acc / longint'(GAIN_ONE);
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        echo_due.push_back(y[SAMPLE_W-1:0]);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void push_item(input logic [MODE_W-1:0] mode,
                                      input logic signed [SAMPLE_W-1:0] sample,
                                      input bit wait_drain = 1'b0);
        echo_req_t r;
        r.mode       = mode;
        r.sample     = sample;
        r.gap        = $urandom_range(0, tx_gap_max);
        r.wait_drain = wait_drain;
        sample_feed.push_back(r);
        if (mode != MODE_IGNORED)
            fed_count++;
    endfunction

    // Clear, a run of samples with some noise, then tail steps to flush the echo
    function automatic void queue_clip(input bit drain_first);
        int n;
        int tails;
        int d;
        d = delay_set;
        push_item(MODE_CLEAR, draw_sample(), drain_first);
        n = $urandom_range(1, 60);
        repeat (n)
        begin
            case ($urandom_range(0, 19))
                0:       push_item(MODE_IGNORED, draw_sample());
                1:       push_item(MODE_TAIL, draw_sample());
                2:       push_item(MODE_CLEAR, draw_sample());
                default: push_item(MODE_SAMPLE, draw_sample());
            endcase
        end
        // mostly a full flush with extra silence, sometimes a short one
        tails = ($urandom_range(0, 4) == 0) ? $urandom_range(0, d) : d + $urandom_range(0, 4);
        repeat (tails)
            push_item(MODE_TAIL, draw_sample());
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_ECHO_GAIN)
            gain_set = data[GAIN_W-1:0];
        else
            delay_set = data[DELAY_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] gain,
                              input logic [CFG_DATA_W-1:0] delay_data);
        write_reg(REG_ECHO_GAIN, gain);
        write_reg(REG_DELAY_SAMPLES, delay_data);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_feed.size() != 0 || in_if.valid || echo_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
        nothing_owed = (echo_due.size() == 0);

    // Input driver
    echo_req_t next_req;
    int        tx_gap_count = 0;
    bit        feed_took;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_if.valid     <= 1'b0;
            in_if.mode      <= MODE_SAMPLE;
            in_if.sample_in <= '0;
        end
        else
        begin
            feed_took = in_if.valid && in_if.ready;
            if (feed_took)
                mix_echo(in_if.mode, in_if.sample_in);
            if (!in_if.valid || in_if.ready)
            begin
                if (sample_feed.size() == 0 ||
                    (sample_feed[0].wait_drain && (feed_took || !nothing_owed)))
                    in_if.valid <= 1'b0;
                else if (tx_gap_count < sample_feed[0].gap)
                begin
                    tx_gap_count++;
                    in_if.valid <= 1'b0;
                end
                else
                begin
                    next_req        = sample_feed.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.mode      <= next_req.mode;
                    in_if.sample_in <= next_req.sample;
                    tx_gap_count    = 0;
                end
            end
        end
    end

    // Output monitor and checker
    logic signed [SAMPLE_W-1:0] due_sample;
    int rx_wait      = 0;
    int rx_hold_left = 0;
    int rx_hold_asks = 0;
    int rx_hold_seen = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (echo_due.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("cycle %0d: unexpected echoed_sample %0d with nothing due",
                                 cycle_count, out_if.echoed_sample);
                    fail_count++;
                end
                else
                begin
                    due_sample = echo_due.pop_front();
                    if (out_if.echoed_sample !== due_sample)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("cycle %0d: echoed_sample expected %0d, got %0d",
                                     cycle_count, due_sample, out_if.echoed_sample);
                        fail_count++;
                    end
                end
                rx_wait = $urandom_range(0, rx_stall_max);
            end
            if (rx_hold_asks != rx_hold_seen)
            begin
                rx_hold_seen = rx_hold_asks;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_feedforward_echo_mixer: done, errors");
            $finish;
        end
    end

    initial
    begin
        int               phase;
        logic [GAIN_W-1:0] g;
        int               d;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: zero gain passes the input straight through
        push_item(MODE_SAMPLE, 16'sh7FFF);
        push_item(MODE_SAMPLE, 16'sh8000);

        // Half gain, short delay, tail steps past the delay, ignored mode, clear mid-clip
        wait_drained();
        set_config(17'd32768, 17'd3);
        push_item(MODE_CLEAR, 16'sh0000);
        push_item(MODE_SAMPLE, 16'sh7FFF);
        push_item(MODE_SAMPLE, 16'sh8000);
        push_item(MODE_SAMPLE, -16'sd1);
        push_item(MODE_SAMPLE, 16'sd1);
        repeat (4) push_item(MODE_TAIL, 16'sh7FFF);
        push_item(MODE_IGNORED, 16'sh1234);
        push_item(MODE_CLEAR, 16'sh8000);
        push_item(MODE_SAMPLE, 16'sd100);

        // Gain above one with zero delay: the delayed term is the input itself
        wait_drained();
        set_config(17'h1FFFF, 17'd0);
        push_item(MODE_SAMPLE, 16'sh8000);
        push_item(MODE_SAMPLE, 16'sh7FFF);
        push_item(MODE_TAIL, -16'sd1);

        // Unity gain, one-sample delay: pure echo
        wait_drained();
        set_config(GAIN_ONE, 17'd1);
        push_item(MODE_CLEAR, -16'sd1);
        push_item(MODE_SAMPLE, 16'sh8000);
        push_item(MODE_SAMPLE, 16'sd12345);
        push_item(MODE_TAIL, 16'sh0000);

        fed_count = 0;
        phase     = 0;
        while (fed_count < RANDOM_ITEMS)
        begin
            wait_drained();
            case (phase % 6)
                0:       g = '0;
                1:       g = GAIN_ONE;
                2:       g = 17'h1FFFF;
                3:       g = 17'd1;
                4:       g = 17'h0FFFF;
                default: g = GAIN_W'($urandom_range(0, 17'h1FFFF));
            endcase
            case (phase % 5)
                0:       d = 0;
                1:       d = 1;
                2:       d = $urandom_range(2, 48);
                3:       d = $urandom_range(1, 8);
                default: d = $urandom_range(9, 40);
            endcase
            // upper data bits are don't-care for the delay register
            set_config(g, {2'($urandom), DELAY_W'(d)});
            tx_gap_max   = (phase % 4 == 3) ? 0 : 7;
            rx_stall_max = (phase % 4 == 3) ? 0 : 7;
            if (phase == 0)
            begin
                // hold the output long while the input keeps coming, so the block backs up
                rx_hold_asks++;
                tx_gap_max = 0;
                push_item(MODE_CLEAR, draw_sample());
                repeat (40) push_item(MODE_SAMPLE, draw_sample());
                tx_gap_max = 7;
            end
            repeat ($urandom_range(1, 3))
                queue_clip(phase == 1 || $urandom_range(0, 3) == 0);
            phase++;
        end

        // Longest delay: the delayed term stays silent for a short clip, no idling
        wait_drained();
        set_config(GAIN_W'($urandom_range(1, 17'h1FFFF)), {2'($urandom), DELAY_W'(LONG_DELAY)});
        tx_gap_max   = 0;
        rx_stall_max = 0;
        push_item(MODE_CLEAR, draw_sample());
        repeat (40)
            push_item(($urandom_range(0, 7) == 0) ? MODE_TAIL : MODE_SAMPLE, draw_sample());

        wait_drained();
        if (fail_count == 0)
            $display("tb_feedforward_echo_mixer: done, clean");
        else
            $display("tb_feedforward_echo_mixer: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ffem_pkg.sv
design/ffem_in_if.sv
design/ffem_out_if.sv
design/ffem_ram.sv
design/ffem_ring.sv
design/ffem_mix.sv
design/feedforward_echo_mixer.sv
bench/tb_feedforward_echo_mixer.sv
